### sv/fpba_pkg.sv
package fpba_pkg;

  // table geometry
  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // transaction queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // placement policies, the unused code behaves as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // classified operation
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } item_t;

  // queue handshake seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

### sv/fpba_front.sv
module fpba_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [3:0]            block_index_i,
  input  logic [15:0]           size_value_i,
  output logic                  push_o,
  output fpba_pkg::item_t       item_o,
  input  logic                  full_i
);

  logic            valid_q, valid_d;
  fpba_pkg::item_t item_q;
  fpba_pkg::item_t item_cls;
  logic            accept;

  // classify the incoming transaction
  always_comb begin
    item_cls.op   = req_type_i ? fpba_pkg::OP_REQUEST : fpba_pkg::OP_LOAD;
    item_cls.idx  = block_index_i[fpba_pkg::IDX_W-1:0];
    item_cls.size = size_value_i[fpba_pkg::SIZE_W-1:0];
  end

  // hold stage, stalls only when the queue is full
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_cls;
    end
  end

endmodule

### sv/fpba_queue.sv
module fpba_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpba_pkg::item_t  item_i,
  output logic             full_o,
  output fpba_pkg::qhead_t head_o,
  input  logic             pop_i
);

  fpba_pkg::item_t                  mem_q [fpba_pkg::QUEUE_DEPTH];
  logic [fpba_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [fpba_pkg::QCNT_W-1:0]      count_q;
  logic                             do_push, do_pop;

  assign full_o       = (count_q == fpba_pkg::QCNT_W'(fpba_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### sv/fpba_back.sv
module fpba_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  fpba_pkg::qhead_t                head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            granted_o,
  output logic [3:0]                      chosen_block_o,
  output logic [15:0]                     space_left_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_CHARGE = 3'b100
  } state_e;

  state_e                             state_q, state_d;
  logic [fpba_pkg::MODE_W-1:0]        mode_q;
  logic [fpba_pkg::CNT_W-1:0]         count_q;
  logic [fpba_pkg::SIZE_W-1:0]        space_q [fpba_pkg::NUM_BLOCKS];
  logic [fpba_pkg::IDX_W-1:0]         k_q, k_d;
  logic [fpba_pkg::IDX_W-1:0]         pick_q, pick_d;
  logic [fpba_pkg::SIZE_W-1:0]        best_q, best_d;
  logic                               have_q, have_d;
  logic                               out_valid_q, out_valid_d;
  logic                               out_granted_q;
  logic [fpba_pkg::IDX_W-1:0]         out_block_q;
  logic [fpba_pkg::SIZE_W-1:0]        out_space_q;
  logic                               out_load;
  logic [fpba_pkg::CNT_W-1:0]         limit;
  logic [fpba_pkg::SIZE_W-1:0]        room;
  logic [fpba_pkg::SIZE_W-1:0]        remain;
  logic                               fits, better, take, last, first_mode;
  logic                               wr_en;
  logic [fpba_pkg::IDX_W-1:0]         wr_idx;
  logic [fpba_pkg::SIZE_W-1:0]        wr_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= fpba_pkg::MODE_FIRST;
      count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fpba_pkg::CFG_FIT_MODE) begin
        mode_q <= cfg_wdata_i[fpba_pkg::MODE_W-1:0];
      end else if (cfg_index_i == fpba_pkg::CFG_BLOCK_COUNT) begin
        count_q <= cfg_wdata_i[fpba_pkg::CNT_W-1:0];
      end
    end
  end

  // search limit clamps at the table size
  assign limit = (count_q > fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS))
               ? fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS) : count_q;

  // per-entry compare for the scan
  assign room       = space_q[k_q];
  assign fits       = (room >= head_i.item.size);
  assign first_mode = (mode_q != fpba_pkg::MODE_BEST) && (mode_q != fpba_pkg::MODE_WORST);
  always_comb begin
    case (mode_q)
      fpba_pkg::MODE_BEST:  better = (room < best_q);
      fpba_pkg::MODE_WORST: better = (room > best_q);
      default:              better = 1'b0;
    endcase
  end
  assign take   = fits && (!have_q || better);
  assign last   = ({1'b0, k_q} == (limit - fpba_pkg::CNT_W'(1)));
  assign remain = best_q - head_i.item.size;

  // sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    pick_d      = pick_q;
    best_d      = best_q;
    have_d      = have_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = head_i.item.idx;
    wr_data     = head_i.item.size;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          if (head_i.item.op == fpba_pkg::OP_LOAD) begin
            wr_en = 1'b1;
            pop_o = 1'b1;
          end else begin
            k_d     = '0;
            pick_d  = '0;
            have_d  = 1'b0;
            state_d = (limit == '0) ? ST_CHARGE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          have_d = 1'b1;
          pick_d = k_q;
          best_d = room;
        end
        k_d = k_q + 1'b1;
        if (last || (fits && first_mode)) begin
          state_d = ST_CHARGE;
        end
      end
      ST_CHARGE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          wr_en       = have_q;
          wr_idx      = pick_q;
          wr_data     = remain;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pick_q <= pick_d;
    best_q <= best_d;
  end

  // free-space table, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
        space_q[i] <= '0;
      end
    end else if (wr_en) begin
      space_q[wr_idx] <= wr_data;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_granted_q <= have_q;
      out_block_q   <= have_q ? pick_q : '0;
      out_space_q   <= have_q ? remain : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = out_granted_q;
  assign chosen_block_o = out_block_q;
  assign space_left_o   = out_space_q;

`ifndef SYNTHESIS
  // scan never runs past the clamped count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, k_q} < limit))
    else $error("scan index beyond block count");

  // a new result only comes out of the charge step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CHARGE))
    else $error("result raised outside charge step");

  // refused result carries zero index and space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_granted_q) |-> (out_block_q == '0 && out_space_q == '0))
    else $error("refused result with nonzero payload");

  // queue is only popped while it holds a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.valid)
    else $error("pop from empty queue");
`endif

endmodule

### sv/fit_policy_block_allocator_core.sv
// load transaction: held in the front stage, queued, then written to the table by the back end
// request transaction: a setup step, then a scan of one entry per cycle (at most
// block_count, first fit stops at the first fitting entry), then a charge step
// the back end handles one transaction at a time, paced by the serial table scan
// reset is asynchronous active low: free-space table, fit_mode and
// block_count all clear to zero, queue and result register empty
module fit_policy_block_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [3:0]  block_index_i,
  input  logic [15:0] size_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        granted_o,
  output logic [3:0]  chosen_block_o,
  output logic [15:0] space_left_o
);

  logic             push;
  logic             full;
  logic             pop;
  fpba_pkg::item_t  item;
  fpba_pkg::qhead_t head;

  // accept and classify
  fpba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .block_index_i (block_index_i),
    .size_value_i  (size_value_i),
    .push_o        (push),
    .item_o        (item),
    .full_i        (full)
  );

  // transaction queue
  fpba_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // table, scan and result
  fpba_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .space_left_o   (space_left_o)
  );

endmodule

### tb/sv/tb_fit_policy_block_allocator_core.sv
module tb_fit_policy_block_allocator_core;
  import fpba_pkg::*;

  // one allocation outcome as seen on the result port
  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  blk;
    logic [SIZE_W-1:0] left;
  } grant_t;

  // tracks the free-space table and the outcomes still owed by the block
  class grant_scoreboard;
    logic [SIZE_W-1:0] room [NUM_BLOCKS];
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  span;
    grant_t            grant_q[$];
    int                errors;

    function new();
      foreach (room[k]) room[k] = '0;
      mode   = MODE_FIRST;
      span   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_FIT_MODE) mode = val[MODE_W-1:0];
      else span = val[CNT_W-1:0];
    endfunction

    // search the used part of the table and charge the chosen block
    function grant_t charge_request(logic [SIZE_W-1:0] need);
      int     lim;
      int     pick;
      bit     have;
      grant_t g;
      lim  = (span > NUM_BLOCKS) ? NUM_BLOCKS : span;
      pick = 0;
      have = 1'b0;
      for (int k = 0; k < lim; k++) begin
        if (room[k] >= need) begin
          if (!have) begin
            have = 1'b1;
            pick = k;
          end else if (mode == MODE_BEST && room[k] < room[pick]) begin
            pick = k;
          end else if (mode == MODE_WORST && room[k] > room[pick]) begin
            pick = k;
          end
        end
      end
      g = '0;
      if (have) begin
        room[pick] = room[pick] - need;
        g.granted  = 1'b1;
        g.blk      = pick[IDX_W-1:0];
        g.left     = room[pick];
      end
      return g;
    endfunction

    function void note_item(item_t it);
      if (it.op == OP_LOAD) room[it.idx] = it.size;
      else grant_q.push_back(charge_request(it.size));
    endfunction

    function void check_result(grant_t got);
      grant_t exp;
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: granted=%0d block=%0d left=%0d",
                   got.granted, got.blk, got.left);
        return;
      end
      exp = grant_q.pop_front();
      if (got.granted !== exp.granted || got.blk !== exp.blk || got.left !== exp.left) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: granted %0d/%0d block %0d/%0d left %0d/%0d (exp/act)",
                   exp.granted, got.granted, exp.blk, got.blk, exp.left, got.left);
      end
    endfunction

    function int pending();
      return grant_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [4:0]        cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  logic [3:0]        block_index_i;
  logic [15:0]       size_value_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              granted_o;
  logic [3:0]        chosen_block_o;
  logic [15:0]       space_left_o;

  grant_scoreboard   sb = new();
  int                burst_left = 0;
  int                stall_style = 0;
  int                style_left = 0;
  int                hold_left = 0;

  fit_policy_block_allocator_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .block_index_i  (block_index_i),
    .size_value_i   (size_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .space_left_o   (space_left_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver stall pattern: free running, random stalls, or long held runs
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(50, 400);
    end
    style_left--;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          hold_left   = $urandom_range(1, 30);
          out_stall_i <= ~out_stall_i;
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{granted_o, chosen_block_o, space_left_o});
  end

  // run watchdog
  initial begin
    #6000000;
    $display("fit_policy_block_allocator_core test failed");
    $finish;
  end

  // send one transaction, idling between bursts
  task automatic push_item(op_e op, logic [3:0] idx, logic [15:0] size);
    int    gap;
    item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    req_type_i    = op;
    block_index_i = idx;
    size_value_i  = size;
    do @(posedge clk_i); while (in_stall_o);
    it.op   = op;
    it.idx  = idx;
    it.size = size;
    sb.note_item(it);
  endtask

  // wait until every grant is back, then let trailing loads drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_policy(logic [1:0] mode, logic [4:0] count);
    settle();
    write_reg(CFG_FIT_MODE, {3'($urandom_range(0, 7)), mode});
    write_reg(CFG_BLOCK_COUNT, count);
  endtask

  // size spread: tiny values give ties, full range toggles every bit
  function automatic logic [15:0] pick_size(int style);
    case (style)
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(4, 12));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  initial begin
    int   sent;
    int   phase_len;
    int   style;
    logic [4:0] count;
    logic [15:0] size;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_FIT_MODE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    req_type_i    = OP_LOAD;
    block_index_i = '0;
    size_value_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero count after reset refuses everything
    push_item(OP_REQUEST, 4'd0, 16'd5);
    set_policy(MODE_FIRST, 5'd16);
    push_item(OP_LOAD, 4'd0, 16'd100);
    push_item(OP_LOAD, 4'd5, 16'hFFFF);
    push_item(OP_LOAD, 4'd15, 16'd300);
    push_item(OP_LOAD, 4'd7, 16'd100);
    // zero-size request, full-size request, request nothing fits
    push_item(OP_REQUEST, 4'd0, 16'd0);
    push_item(OP_REQUEST, 4'd0, 16'hFFFF);
    push_item(OP_REQUEST, 4'd0, 16'd400);
    // best fit with a tie on the smallest room
    set_policy(MODE_BEST, 5'd16);
    push_item(OP_REQUEST, 4'd9, 16'd50);
    push_item(OP_REQUEST, 4'd9, 16'd60);
    // worst fit with a tie on the largest room
    set_policy(MODE_WORST, 5'd16);
    push_item(OP_REQUEST, 4'd3, 16'd10);
    push_item(OP_LOAD, 4'd3, 16'd290);
    push_item(OP_REQUEST, 4'd3, 16'd1);
    // load beyond the count is kept but not searched, unused mode code
    set_policy(2'd3, 5'd4);
    push_item(OP_LOAD, 4'd10, 16'd1000);
    push_item(OP_REQUEST, 4'd0, 16'd500);
    // count beyond the table
    set_policy(MODE_WORST, 5'd31);
    push_item(OP_REQUEST, 4'd0, 16'd500);
    push_item(OP_REQUEST, 4'hF, 16'h8000);
    set_policy(2'd3, 5'd16);
    push_item(OP_REQUEST, 4'd0, 16'd20);

    // random phases: fill the table, then mixed loads and requests
    sent = 0;
    while (sent < 1550) begin
      case ($urandom_range(0, 9))
        0: count = 5'd0;
        1: count = 5'd1;
        2, 3: count = 5'd16;
        4: count = 5'd31;
        default: count = 5'($urandom_range(2, 17));
      endcase
      set_policy(2'($urandom_range(0, 3)), count);
      style = $urandom_range(0, 2);
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        push_item(OP_LOAD, 4'(k), pick_size(style));
        sent++;
      end
      phase_len = $urandom_range(80, 200);
      for (int n = 0; n < phase_len; n++) begin
        size = pick_size(style);
        if ($urandom_range(0, 19) == 0)
          size = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
        if ($urandom_range(0, 9) < 3) begin
          push_item(OP_LOAD, 4'($urandom_range(0, 15)), size);
        end else begin
          if (style == 2) size = size >> $urandom_range(0, 8);
          push_item(OP_REQUEST, 4'($urandom_range(0, 15)), size);
        end
        sent++;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fit_policy_block_allocator_core test passed");
    end else begin
      $display("fit_policy_block_allocator_core test failed");
    end
    $finish;
  end

endmodule
